// ----- rtl/bsde_pkg.sv -----
// Package for the B-spline de Boor point evaluator.
// Holds request codes, the register index codes, the size limits and the blend helper;
// no dependencies.
package bsde_pkg;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	localparam int REG_ORDER = 0;
	localparam int REG_COUNT = 1;

	// Size of the control-point stores and the highest supported order.
	localparam int MAX_POINTS = 64;
	localparam int MAX_ORDER  = 8;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Blend (w*a + (1-w)*b) >> 16 with floor, written as b + (w*(a-b) >> 16).
	function automatic logic signed [15:0] blend_f(input logic [16:0] w,
			input logic signed [15:0] a, input logic signed [15:0] b);
		logic signed [17:0] diff;
		logic signed [35:0] prod;
		logic signed [35:0] sum;
		diff = 18'(a) - 18'(b);
		prod = $signed({1'b0, w}) * diff;
		sum  = (prod >>> 16) + 36'(b);
		return sum[15:0];
	endfunction

endpackage

// ----- rtl/bsde_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/bsde_div.sv -----
// Restoring divider for blend weights: quotient of a 23-bit numerator by a small denominator.
// One quotient bit per cycle; no dependencies.
module bsde_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [22:0] num,
	input  logic [6:0]  den,
	output logic        done,
	output logic [22:0] quo
);
	logic [22:0] num_q;
	logic [6:0]  rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [7:0]  trial;

	assign trial = {rem_q, num_q[22]};

	// Shift and subtract, MSB first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= num;
				rem_q  <= '0;
				cnt_q  <= 5'd23;
				quo    <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[21:0], 1'b0};
				if (trial >= {1'b0, den}) begin
					rem_q <= 7'(trial - {1'b0, den});
					quo   <= {quo[21:0], 1'b1};
				end else begin
					rem_q <= trial[6:0];
					quo   <= {quo[21:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/bspline_de_boor_point_eval_unit.sv -----
// B-spline de Boor point evaluator, top level.
// Uses bsde_pkg, bsde_ram (control-point stores) and bsde_div (weight divider).
//
// Usage: one input channel (valid/ready) carries write and evaluate transactions; one
// output channel (valid/ready) returns one result per evaluate transaction. An APB-style
// port holds curve_order (address 0) and point_count (address 4).
// A write transaction stores one control point in the x and y memories.
// An evaluate transaction fetches k points from the memories (one per cycle, through
// the registered read ports), then runs k(k-1)/2 blend steps. Each step starts the
// serial divider, waits for its quotient and then blends two neighbouring points.
// A bad configuration goes straight to the done state and answers with status set.
// One transaction is worked at a time; the result sits in an output register, and a new
// input transaction is taken while it waits, but the next result waits for that register.
// Reset clears control state and the registers to order 2 and count 2; the point memories
// are undefined until written.
module bspline_de_boor_point_eval_unit
	import bsde_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [5:0]         point_index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [16:0]        param_u,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] curve_x,
	output logic signed [15:0] curve_y,
	output logic [5:0]         span_found,
	output logic               status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int OW = $clog2(MAX_ORDER);

	typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_DIV, ST_WAITDIV, ST_BLEND, ST_DONE}
		state_t;

	state_t state_q;
	logic [3:0]  order_q;
	logic [6:0]  count_q;
	logic signed [15:0] px_q [MAX_ORDER];
	logic signed [15:0] py_q [MAX_ORDER];
	logic [6:0]  d_q;
	logic [22:0] uu_q;
	logic [3:0]  r_q;
	logic [3:0]  s_q;
	logic [3:0]  fcnt_q;
	logic [3:0]  fcnt_s1;
	logic        fvld_s1;
	logic [16:0] w_q;
	logic        obusy_q;
	logic        bad_q;
	logic signed [15:0] rx_q, ry_q;
	logic [5:0]  rd_q;
	logic        rst_q;

	// Register file.
	assign pready = 1'b1;
	always_comb begin
		unique case (int'(paddr[2]))
			REG_ORDER: prdata = {28'd0, order_q};
			REG_COUNT: prdata = {25'd0, count_q};
			default:   prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 4'd2;
			count_q <= 7'd2;
		end else if (psel && penable && pwrite) begin
			if (int'(paddr[2]) == REG_ORDER)
				order_q <= pwdata[3:0];
			else
				count_q <= pwdata[6:0];
		end
	end

	// Memories.
	logic            wr_en;
	logic [AW-1:0]   raddr;
	logic [15:0]     rx, ry;
	logic [6:0]      fidx;
	assign wr_en = in_valid && in_ready && req_type == REQ_WRITE &&
		{1'b0, point_index} < 7'(MAX_POINTS);
	assign fidx  = d_q - 7'(fcnt_q);
	assign raddr = AW'(fidx);
	bsde_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_xram (.clk(clk), .we(wr_en),
		.waddr(AW'(point_index)), .wdata(point_x), .raddr(raddr), .rdata(rx));
	bsde_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_yram (.clk(clk), .we(wr_en),
		.waddr(AW'(point_index)), .wdata(point_y), .raddr(raddr), .rdata(ry));

	// Knot values in span units.
	function automatic logic [6:0] knot_f(input logic [7:0] i, input logic [3:0] k,
			input logic [6:0] n);
		if (i < 8'(k))
			return 7'd0;
		if (i < 8'(n))
			return 7'(i - 8'(k) + 8'd1);
		return 7'(n - 7'(k) + 7'd1);
	endfunction

	logic [7:0]  ki;
	logic [6:0]  ti, den;
	logic [22:0] base, num;
	assign ki   = 8'(d_q) - 8'(s_q);
	assign ti   = knot_f(ki, order_q, count_q);
	assign den  = knot_f(ki + 8'(r_q) - 8'd1, order_q, count_q) - ti;
	assign base = {ti, 16'd0};
	assign num  = (uu_q > base) ? uu_q - base : 23'd0;

	logic div_start, div_done;
	logic [22:0] quo;
	assign div_start = (state_q == ST_DIV);
	bsde_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(num),
		.den((den == 7'd0) ? 7'd1 : den), .done(div_done), .quo(quo));

	// Input decoding for an evaluate transaction.
	logic        bad;
	logic [16:0] usat;
	logic [6:0]  nsp;
	logic [22:0] uprod;
	logic [6:0]  fl;
	assign bad   = order_q < 4'd2 || 32'(order_q) > MAX_ORDER ||
		32'(count_q) > MAX_POINTS || count_q < 7'(order_q);
	assign usat  = (param_u > ONE_Q16) ? ONE_Q16 : param_u;
	assign nsp   = count_q - 7'(order_q) + 7'd1;
	assign uprod = 23'(usat) * 23'(nsp);
	assign fl    = (uprod[22:16] > nsp - 7'd1) ? nsp - 7'd1 : uprod[22:16];

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = obusy_q;
	assign curve_x   = rx_q;
	assign curve_y   = ry_q;
	assign span_found = rd_q;
	assign status    = rst_q;

	// Sequencer with the working registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			obusy_q <= 1'b0;
			fvld_s1 <= 1'b0;
		end else begin
			// The output register fills from the done state and empties when taken.
			if (state_q == ST_DONE && (!obusy_q || out_ready))
				obusy_q <= 1'b1;
			else if (obusy_q && out_ready)
				obusy_q <= 1'b0;
			fvld_s1 <= (state_q == ST_FETCH) && (fcnt_q < order_q);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready && req_type == REQ_EVAL) begin
						if (bad) begin
							bad_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							uu_q    <= uprod;
							d_q     <= 7'(order_q) - 7'd1 + fl;
							fcnt_q  <= '0;
							r_q     <= order_q;
							s_q     <= '0;
							bad_q   <= 1'b0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					if (fcnt_q < order_q) begin
						fcnt_s1 <= fcnt_q;
						fcnt_q  <= fcnt_q + 4'd1;
					end
					if (fvld_s1) begin
						px_q[OW'(fcnt_s1)] <= rx;
						py_q[OW'(fcnt_s1)] <= ry;
						if (fcnt_s1 == order_q - 4'd1)
							state_q <= ST_DIV;
					end
				end
				ST_DIV: state_q <= ST_WAITDIV;
				ST_WAITDIV: begin
					if (div_done) begin
						if (den == 7'd0 || quo > 23'(ONE_Q16))
							w_q <= ONE_Q16;
						else
							w_q <= quo[16:0];
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					px_q[OW'(s_q)] <= blend_f(w_q, px_q[OW'(s_q)], px_q[OW'(s_q + 4'd1)]);
					py_q[OW'(s_q)] <= blend_f(w_q, py_q[OW'(s_q)], py_q[OW'(s_q + 4'd1)]);
					if (s_q + 4'd2 < r_q) begin
						s_q <= s_q + 4'd1;
						state_q <= ST_DIV;
					end else if (r_q > 4'd2) begin
						s_q <= '0;
						r_q <= r_q - 4'd1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!obusy_q || out_ready) begin
						rx_q <= bad_q ? '0 : px_q[0];
						ry_q <= bad_q ? '0 : py_q[0];
						rd_q <= bad_q ? 6'd0 : d_q[5:0];
						rst_q <= bad_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/bsde_checker.sv -----
// Port-level checker for the B-spline evaluator, with its bind statement.
// Depends on bsde_pkg and the top level bspline_de_boor_point_eval_unit.
module bsde_props
	import bsde_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic        out_valid,
	input logic        out_ready,
	input logic        status,
	input logic [5:0]  span_found,
	input logic signed [15:0] curve_x,
	input logic        pready
);
	// A waiting result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(curve_x) && $stable(status))
		else $error("result changed while stalled");
	// A bad-configuration result carries zeros.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> span_found == 6'd0 && curve_x == 16'sd0)
		else $error("status result not zero");
	// The register port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	// The input closes while an evaluate transaction is being worked.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_EVAL |=> !in_ready)
		else $error("input open during evaluation");
endmodule

bind bspline_de_boor_point_eval_unit bsde_props u_bsde_props (.clk(clk),
	.arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.span_found(span_found), .curve_x(curve_x), .pready(pready));
